FILE: sv/tgr_pkg.sv
// Shared types and constants for the text glyph renderer.
package tgr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PLACE,
        ST_WIN,
        ST_ROW
    } t_state;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_FONT_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FONT_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE_GAP    = 2'd2;

    localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
    localparam logic [5:0] FONT_HEIGHT_RST = 6'd10;
    localparam logic [3:0] LINE_GAP_RST    = 4'd2;

    localparam logic       ACT_LOAD   = 1'b0;
    localparam logic       KIND_WIN   = 1'b0;
    localparam logic       KIND_ROW   = 1'b1;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [9:0] COORD_MAX  = 10'd1023;
    localparam logic [4:0] ROW_BITS_W = 5'd16;
    localparam int         ADDR_EXT_W = 17;

endpackage

FILE: sv/text_glyph_renderer_unit.sv
// Character generator: glyph store, cursor placement and row word output.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | i_in_valid/o_in_ready | load or render request
//  out     | output    | o_out_valid/i_out_ready | window command or glyph row
//  cfg     | input     | APB psel/penable      | font_width, font_height, line_gap
//
// A load writes the glyph store when taken. A render sets the cursor in ST_WRAP
// and ST_PLACE, then sends the window command and fh rows, one store read per row.
// Rows stream at one per cycle while the output is taken; a stalled output
// holds the read pipeline in place. Synchronous active-low reset clears the
// cursor, stopped flag, config and handshake state; the glyph store is not
// cleared.
module text_glyph_renderer_unit #(
    parameter int SCREEN_WIDTH   = 240,
    parameter int SCREEN_HEIGHT  = 320,
    parameter int GLYPH_WORDS    = 4096,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [11:0] i_glyph_address,
    input  logic [15:0] i_glyph_word,
    input  logic        i_starts_string,
    input  logic [7:0]  i_origin_x,
    input  logic [8:0]  i_origin_y,
    input  logic [7:0]  i_character,
    input  logic [15:0] i_fore_color,
    input  logic [15:0] i_back_color,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_window_x0,
    output logic [8:0]  o_window_y0,
    output logic [7:0]  o_window_x1,
    output logic [8:0]  o_window_y1,
    output logic [15:0] o_row_bits,
    output logic [4:0]  o_pixel_count,
    output logic [15:0] o_pen_color,
    output logic [15:0] o_paper_color,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(GLYPH_WORDS);
    localparam int XW = tgr_pkg::ADDR_EXT_W;

    // configuration
    logic [4:0] r_font_width;
    logic [5:0] r_font_height;
    logic [3:0] r_line_gap;

    // control state
    tgr_pkg::t_state r_state, n_state;
    logic [9:0]  r_cursor_col, n_cursor_col;
    logic [9:0]  r_cursor_row, n_cursor_row;
    logic [7:0]  r_line_start, n_line_start;
    logic        r_stopped, n_stopped;
    logic        r_out_valid, n_out_valid;
    logic [5:0]  r_row, n_row;

    // item payload
    logic [7:0]  r_code;
    logic [15:0] r_fore, r_back;
    logic [13:0] r_base, n_base;
    logic [9:0]  r_x, n_x;
    logic [9:0]  r_y, n_y;

    // output word
    logic        r_kind, n_kind;
    logic [7:0]  r_wx0, n_wx0;
    logic [8:0]  r_wy0, n_wy0;
    logic [7:0]  r_wx1, n_wx1;
    logic [8:0]  r_wy1, n_wy1;
    logic [15:0] r_bits, n_bits;
    logic [4:0]  r_pcnt, n_pcnt;
    logic [15:0] r_pen, n_pen;
    logic [15:0] r_paper, n_paper;
    logic        r_last, n_last;

    // glyph store
    logic [15:0] r_store [GLYPH_WORDS];
    logic [15:0] r_rd_q;
    logic        rd_en;
    logic [XW-1:0] rd_addr;
    logic        wr_en;
    logic [XW-1:0] wr_addr;

    logic [4:0]  fw;
    logic [5:0]  fh;
    logic        in_acc;
    logic        slot_free;
    logic        cfg_wr;
    logic [10:0] col_end;
    logic [10:0] row_wrap;
    logic [10:0] row_end;
    logic [XW-1:0] glyph_end;
    logic        row_is_last;
    logic [15:0] row_mask;

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == tgr_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign cfg_wr     = psel && penable && pwrite;

    // effective font size
    always_comb begin
        if (r_font_width == 5'd0) begin
            fw = 5'd1;
        end else if (r_font_width > tgr_pkg::ROW_BITS_W) begin
            fw = tgr_pkg::ROW_BITS_W;
        end else begin
            fw = r_font_width;
        end
        if (r_font_height == 6'd0) begin
            fh = 6'd1;
        end else if (r_font_height > 6'(MAX_GLYPH_ROWS)) begin
            fh = 6'(MAX_GLYPH_ROWS);
        end else begin
            fh = r_font_height;
        end
    end

    assign col_end     = 11'(r_cursor_col) + 11'(fw);
    assign row_wrap    = 11'(r_cursor_row) + 11'(fh) + 11'(r_line_gap);
    assign row_end     = 11'(r_cursor_row) + 11'(fh);
    assign glyph_end   = XW'(r_base) + XW'(fh);
    assign row_is_last = (r_row == fh - 6'd1);
    assign row_mask    = 16'hFFFF << (tgr_pkg::ROW_BITS_W - fw);

    always_comb begin
        case (paddr[3:2])
            tgr_pkg::REG_FONT_WIDTH:  prdata = 32'(r_font_width);
            tgr_pkg::REG_FONT_HEIGHT: prdata = 32'(r_font_height);
            tgr_pkg::REG_LINE_GAP:    prdata = 32'(r_line_gap);
            default:                  prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgr_pkg::ST_IDLE: begin
                if (in_acc && i_action != tgr_pkg::ACT_LOAD) begin
                    n_state = tgr_pkg::ST_WRAP;
                end
            end
            tgr_pkg::ST_WRAP: begin
                n_state = r_stopped ? tgr_pkg::ST_IDLE : tgr_pkg::ST_PLACE;
            end
            tgr_pkg::ST_PLACE: begin
                if (row_end > 11'(SCREEN_HEIGHT)
                        || col_end > 11'(SCREEN_WIDTH)
                        || r_code < tgr_pkg::FIRST_CODE
                        || glyph_end > XW'(GLYPH_WORDS)) begin
                    n_state = tgr_pkg::ST_IDLE;
                end else begin
                    n_state = tgr_pkg::ST_WIN;
                end
            end
            tgr_pkg::ST_WIN: begin
                if (slot_free) begin
                    n_state = tgr_pkg::ST_ROW;
                end
            end
            tgr_pkg::ST_ROW: begin
                if (slot_free && row_is_last) begin
                    n_state = tgr_pkg::ST_IDLE;
                end
            end
            default: n_state = tgr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cursor_col = r_cursor_col;
        n_cursor_row = r_cursor_row;
        n_line_start = r_line_start;
        n_stopped    = r_stopped;
        n_base       = r_base;
        n_x          = r_x;
        n_y          = r_y;
        n_row        = r_row;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_kind       = r_kind;
        n_wx0        = r_wx0;
        n_wy0        = r_wy0;
        n_wx1        = r_wx1;
        n_wy1        = r_wy1;
        n_bits       = r_bits;
        n_pcnt       = r_pcnt;
        n_pen        = r_pen;
        n_paper      = r_paper;
        n_last       = r_last;
        rd_en        = 1'b0;
        rd_addr      = XW'(r_base) + XW'(r_row);
        wr_en        = 1'b0;
        wr_addr      = XW'(i_glyph_address);
        case (r_state)
            tgr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_action == tgr_pkg::ACT_LOAD) begin
                        wr_en = (wr_addr < XW'(GLYPH_WORDS));
                    end else if (i_starts_string) begin
                        n_line_start = i_origin_x;
                        n_cursor_col = 10'(i_origin_x);
                        n_cursor_row = 10'(i_origin_y);
                        n_stopped    = 1'b0;
                    end
                end
            end
            tgr_pkg::ST_WRAP: begin
                n_base = 14'(r_code - tgr_pkg::FIRST_CODE) * 14'(fh);
                if (!r_stopped && col_end > 11'(SCREEN_WIDTH)) begin
                    n_cursor_col = 10'(r_line_start);
                    n_cursor_row = (row_wrap > 11'(tgr_pkg::COORD_MAX))
                                 ? tgr_pkg::COORD_MAX : row_wrap[9:0];
                end
            end
            tgr_pkg::ST_PLACE: begin
                if (row_end > 11'(SCREEN_HEIGHT)) begin
                    n_stopped = 1'b1;
                end else begin
                    n_x = r_cursor_col;
                    n_y = r_cursor_row;
                    n_cursor_col = (col_end > 11'(tgr_pkg::COORD_MAX))
                                 ? tgr_pkg::COORD_MAX : col_end[9:0];
                end
            end
            tgr_pkg::ST_WIN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = tgr_pkg::KIND_WIN;
                    n_wx0       = r_x[7:0];
                    n_wy0       = r_y[8:0];
                    n_wx1       = 8'(r_x + 10'(fw) - 10'd1);
                    n_wy1       = 9'(r_y + 10'(fh) - 10'd1);
                    n_bits      = 16'd0;
                    n_pcnt      = 5'd0;
                    n_pen       = 16'd0;
                    n_paper     = 16'd0;
                    n_last      = 1'b0;
                    // fetch the first row while the window word waits
                    n_row       = 6'd0;
                    rd_en       = 1'b1;
                    rd_addr     = XW'(r_base);
                end
            end
            tgr_pkg::ST_ROW: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = tgr_pkg::KIND_ROW;
                    n_wx0       = 8'd0;
                    n_wy0       = 9'd0;
                    n_wx1       = 8'd0;
                    n_wy1       = 9'd0;
                    n_bits      = r_rd_q & row_mask;
                    n_pcnt      = fw;
                    n_pen       = r_fore;
                    n_paper     = r_back;
                    n_last      = row_is_last;
                    if (!row_is_last) begin
                        n_row   = r_row + 6'd1;
                        rd_en   = 1'b1;
                        rd_addr = XW'(r_base) + XW'(r_row) + XW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tgr_pkg::ST_IDLE;
            r_font_width  <= tgr_pkg::FONT_WIDTH_RST;
            r_font_height <= tgr_pkg::FONT_HEIGHT_RST;
            r_line_gap    <= tgr_pkg::LINE_GAP_RST;
            r_cursor_col  <= 10'd0;
            r_cursor_row  <= 10'd0;
            r_line_start  <= 8'd0;
            r_stopped     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_row         <= 6'd0;
        end else begin
            r_state      <= n_state;
            r_cursor_col <= n_cursor_col;
            r_cursor_row <= n_cursor_row;
            r_line_start <= n_line_start;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
            r_row        <= n_row;
            if (cfg_wr) begin
                case (paddr[3:2])
                    tgr_pkg::REG_FONT_WIDTH:  r_font_width  <= pwdata[4:0];
                    tgr_pkg::REG_FONT_HEIGHT: r_font_height <= pwdata[5:0];
                    tgr_pkg::REG_LINE_GAP:    r_line_gap    <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_character;
            r_fore <= i_fore_color;
            r_back <= i_back_color;
        end
        r_base  <= n_base;
        r_x     <= n_x;
        r_y     <= n_y;
        r_kind  <= n_kind;
        r_wx0   <= n_wx0;
        r_wy0   <= n_wy0;
        r_wx1   <= n_wx1;
        r_wy1   <= n_wy1;
        r_bits  <= n_bits;
        r_pcnt  <= n_pcnt;
        r_pen   <= n_pen;
        r_paper <= n_paper;
        r_last  <= n_last;
    end

    // glyph store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr[AW-1:0]] <= i_glyph_word;
        end
        if (rd_en) begin
            r_rd_q <= r_store[rd_addr[AW-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_window_x0   = r_wx0;
    assign o_window_y0   = r_wy0;
    assign o_window_x1   = r_wx1;
    assign o_window_y1   = r_wy1;
    assign o_row_bits    = r_bits;
    assign o_pixel_count = r_pcnt;
    assign o_pen_color   = r_pen;
    assign o_paper_color = r_paper;
    assign o_last        = r_last;

endmodule

FILE: tb/text_glyph_renderer_unit_tb.sv
// Self-checking testbench for the text glyph renderer: loads, cursor placement, row words.
`timescale 1ns / 100ps

module text_glyph_renderer_unit_tb;

    localparam int SCREEN_W      = 240;
    localparam int SCREEN_H      = 320;
    localparam int STORE_WORDS   = 4096;
    localparam int MAX_ROWS      = 32;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam logic ACT_DRAW    = ~tgr_pkg::ACT_LOAD;

    typedef struct packed {
        logic        action;
        logic [11:0] glyph_address;
        logic [15:0] glyph_word;
        logic        starts_string;
        logic [7:0]  origin_x;
        logic [8:0]  origin_y;
        logic [7:0]  character;
        logic [15:0] fore_color;
        logic [15:0] back_color;
    } t_draw_req;

    typedef struct packed {
        logic        kind;
        logic [7:0]  x0;
        logic [8:0]  y0;
        logic [7:0]  x1;
        logic [8:0]  y1;
        logic [15:0] row_bits;
        logic [4:0]  pixel_count;
        logic [15:0] pen;
        logic [15:0] paper;
        logic        last;
    } t_draw_word;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_vld  = 1'b0;
    logic        out_rdy = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_window_x0;
    logic [8:0]  o_window_y0;
    logic [7:0]  o_window_x1;
    logic [8:0]  o_window_y1;
    logic [15:0] o_row_bits;
    logic [4:0]  o_pixel_count;
    logic [15:0] o_pen_color;
    logic [15:0] o_paper_color;
    logic        o_last;

    t_draw_req   cur_req = '0;
    t_draw_req   pending_reqs[$];
    t_draw_word  expected_words[$];
    t_draw_word  got_word;
    t_draw_word  want_word;

    logic        in_taken      = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          queued_cnt    = 0;
    int          accepted_cnt  = 0;
    int          mismatch_cnt  = 0;
    int          stall_cycles  = 0;

    // predictor state
    logic [4:0]  cfg_width  = tgr_pkg::FONT_WIDTH_RST;
    logic [5:0]  cfg_height = tgr_pkg::FONT_HEIGHT_RST;
    logic [3:0]  cfg_gap    = tgr_pkg::LINE_GAP_RST;
    int unsigned cur_col    = 0;
    int unsigned cur_row    = 0;
    int unsigned line_col   = 0;
    logic        stopped    = 1'b0;
    logic [15:0] glyph_mem[STORE_WORDS];
    // store words already loaded by the stimulus, so no unwritten word is read
    logic        loaded[STORE_WORDS];

    text_glyph_renderer_unit #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .GLYPH_WORDS   (STORE_WORDS),
        .MAX_GLYPH_ROWS(MAX_ROWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_vld),
        .o_in_ready     (o_in_ready),
        .i_action       (cur_req.action),
        .i_glyph_address(cur_req.glyph_address),
        .i_glyph_word   (cur_req.glyph_word),
        .i_starts_string(cur_req.starts_string),
        .i_origin_x     (cur_req.origin_x),
        .i_origin_y     (cur_req.origin_y),
        .i_character    (cur_req.character),
        .i_fore_color   (cur_req.fore_color),
        .i_back_color   (cur_req.back_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_rdy),
        .o_kind         (o_kind),
        .o_window_x0    (o_window_x0),
        .o_window_y0    (o_window_y0),
        .o_window_x1    (o_window_x1),
        .o_window_y1    (o_window_y1),
        .o_row_bits     (o_row_bits),
        .o_pixel_count  (o_pixel_count),
        .o_pen_color    (o_pen_color),
        .o_paper_color  (o_paper_color),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > tgr_pkg::ROW_BITS_W) return tgr_pkg::ROW_BITS_W;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_ROWS) return MAX_ROWS;
        return cfg_height;
    endfunction

    function automatic int unsigned clip_coord(input int unsigned v);
        return (v > tgr_pkg::COORD_MAX) ? tgr_pkg::COORD_MAX : v;
    endfunction

    function automatic string word_text(input t_draw_word w);
        return $sformatf("kind=%0d win=(%0d,%0d)-(%0d,%0d) bits=%h n=%0d pen=%h paper=%h last=%0d",
                         w.kind, w.x0, w.y0, w.x1, w.y1, w.row_bits, w.pixel_count,
                         w.pen, w.paper, w.last);
    endfunction

    // Works out the out words caused by one accepted request.
    task automatic predict_glyph_words(input t_draw_req r);
        int unsigned fw, fh, x, y, base;
        logic [15:0] mask;
        t_draw_word  w;
        if (r.action == tgr_pkg::ACT_LOAD) begin
            if (r.glyph_address < STORE_WORDS) glyph_mem[r.glyph_address] = r.glyph_word;
        end else begin
            fw = eff_width();
            fh = eff_height();
            if (r.starts_string) begin
                line_col = r.origin_x;
                cur_col  = r.origin_x;
                cur_row  = r.origin_y;
                stopped  = 1'b0;
            end
            if (!stopped) begin
                if (cur_col + fw > SCREEN_W) begin
                    cur_col = line_col;
                    cur_row = clip_coord(cur_row + fh + cfg_gap);
                end
                if (cur_row + fh > SCREEN_H) begin
                    stopped = 1'b1;
                end else begin
                    x = cur_col;
                    y = cur_row;
                    cur_col = clip_coord(cur_col + fw);
                    if (x + fw <= SCREEN_W && r.character >= tgr_pkg::FIRST_CODE) begin
                        base = (int'(r.character) - int'(tgr_pkg::FIRST_CODE)) * fh;
                        if (base + fh <= STORE_WORDS) begin
                            w      = '0;
                            w.kind = tgr_pkg::KIND_WIN;
                            w.x0   = 8'(x);
                            w.y0   = 9'(y);
                            w.x1   = 8'(x + fw - 1);
                            w.y1   = 9'(y + fh - 1);
                            expected_words.push_back(w);
                            mask = 16'hFFFF << (tgr_pkg::ROW_BITS_W - fw);
                            for (int k = 0; k < fh; k++) begin
                                w             = '0;
                                w.kind        = tgr_pkg::KIND_ROW;
                                w.row_bits    = glyph_mem[base + k] & mask;
                                w.pixel_count = 5'(fw);
                                w.pen         = r.fore_color;
                                w.paper       = r.back_color;
                                w.last        = (k == fh - 1);
                                expected_words.push_back(w);
                            end
                        end
                    end
                end
            end
        end
    endtask

    // input and output monitor
    always @(posedge i_clk) begin
        stall_cycles = stall_cycles + 1;
        if (i_rst_n) begin
            if (in_vld && o_in_ready) begin
                predict_glyph_words(cur_req);
                accepted_cnt = accepted_cnt + 1;
                in_taken     = 1'b1;
                stall_cycles = 0;
            end
            if (o_out_valid && out_rdy) begin
                stall_cycles = 0;
                got_word = '{o_kind, o_window_x0, o_window_y0, o_window_x1, o_window_y1,
                             o_row_bits, o_pixel_count, o_pen_color, o_paper_color, o_last};
                if (expected_words.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10)
                        $display("unexpected out word: %s", word_text(got_word));
                end else begin
                    want_word = expected_words.pop_front();
                    if (got_word !== want_word) begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= 10)
                            $display("out word mismatch\n  exp %s\n  got %s",
                                     word_text(want_word), word_text(got_word));
                    end
                end
            end
        end
    end

    // request driver and output stall generator
    always @(negedge i_clk) begin
        out_rdy = ($urandom_range(0, 99) >= recv_idle_pct);
        if (in_taken || !in_vld) begin
            in_taken = 1'b0;
            if (i_rst_n && pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                in_vld  = 1'b1;
            end else begin
                in_vld = 1'b0;
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            tgr_pkg::REG_FONT_WIDTH:  cfg_width  = val[4:0];
            tgr_pkg::REG_FONT_HEIGHT: cfg_height = val[5:0];
            tgr_pkg::REG_LINE_GAP:    cfg_gap    = val[3:0];
            default: ;
        endcase
        stall_cycles = 0;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_font(input logic [31:0] w, input logic [31:0] h, input logic [31:0] g);
        write_reg(tgr_pkg::REG_FONT_WIDTH, w);
        write_reg(tgr_pkg::REG_FONT_HEIGHT, h);
        write_reg(tgr_pkg::REG_LINE_GAP, g);
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_words.size() != 0) @(posedge i_clk);
    endtask

    // a load leaves no out word, so allow the block to finish its last request
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_load(input logic [11:0] addr, input logic [15:0] data);
        t_draw_req r;
        r.action        = tgr_pkg::ACT_LOAD;
        r.glyph_address = addr;
        r.glyph_word    = data;
        r.starts_string = 1'($urandom_range(0, 1));
        r.origin_x      = 8'($urandom_range(0, 239));
        r.origin_y      = 9'($urandom_range(0, 319));
        r.character     = 8'($urandom_range(0, 255));
        r.fore_color    = 16'($urandom_range(0, 65535));
        r.back_color    = 16'($urandom_range(0, 65535));
        pending_reqs.push_back(r);
        loaded[addr] = 1'b1;
        queued_cnt   = queued_cnt + 1;
    endtask

    task automatic queue_char(input logic start, input logic [7:0] ox, input logic [8:0] oy,
                              input logic [7:0] code, input logic [15:0] fg,
                              input logic [15:0] bg);
        t_draw_req   r;
        int unsigned fh, base;
        fh = eff_height();
        if (code >= tgr_pkg::FIRST_CODE) begin
            base = (int'(code) - int'(tgr_pkg::FIRST_CODE)) * fh;
            if (base + fh <= STORE_WORDS)
                for (int k = 0; k < fh; k++)
                    if (!loaded[base + k])
                        queue_load(12'(base + k), 16'($urandom_range(0, 65535)));
        end
        r.action        = ACT_DRAW;
        r.glyph_address = 12'($urandom_range(0, 4095));
        r.glyph_word    = 16'($urandom_range(0, 65535));
        r.starts_string = start;
        r.origin_x      = ox;
        r.origin_y      = oy;
        r.character     = code;
        r.fore_color    = fg;
        r.back_color    = bg;
        pending_reqs.push_back(r);
        queued_cnt = queued_cnt + 1;
    endtask

    // a few codes share the low store words, so their glyph loads stay few
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 99) < 90) return 8'($urandom_range(32, 34));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_row();
        if ($urandom_range(0, 99) < 70) return 9'($urandom_range(0, 160));
        return 9'($urandom_range(0, 319));
    endfunction

    task automatic random_phase(input int sidle, input int ridle, input int n_items,
                                input bit pause_mid);
        int pick, first;
        bit paused;
        settle();
        write_reg(tgr_pkg::REG_FONT_WIDTH, 32'($urandom_range(1, 16)));
        write_reg(tgr_pkg::REG_FONT_HEIGHT, 32'($urandom_range(1, 6)));
        write_reg(tgr_pkg::REG_LINE_GAP, 32'($urandom_range(0, 15)));
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        first  = queued_cnt;
        paused = 1'b0;
        while (queued_cnt - first < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                queue_load(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
            end else begin
                // now and then a new string, else continue whatever string state is left
                queue_char(pick < 35, 8'($urandom_range(0, 239)), pick_row(), pick_code(),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
            if (pause_mid && !paused && queued_cnt - first >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        foreach (loaded[k]) loaded[k] = 1'b0;
        foreach (glyph_mem[k]) glyph_mem[k] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 85;

        // reset font: a drawn glyph, unprintable codes
        queue_char(1'b1, 8'd0, 9'd0, 8'd65, 16'hFFFF, 16'h0000);
        queue_char(1'b0, 8'd0, 9'd0, 8'd31, 16'h1234, 16'hABCD);
        queue_char(1'b0, 8'd0, 9'd0, 8'd0, 16'h1234, 16'hABCD);
        // origin at the right edge: wrap, then glyph too wide
        queue_char(1'b1, 8'd239, 9'd0, 8'd65, 16'hF800, 16'h07E0);
        queue_char(1'b0, 8'd0, 9'd0, 8'd65, 16'hF800, 16'h07E0);
        // origin at the bottom: stops, and stays stopped
        queue_char(1'b1, 8'd0, 9'd319, 8'd65, 16'h001F, 16'h0000);
        queue_char(1'b0, 8'd0, 9'd0, 8'd65, 16'h001F, 16'h0000);
        // a line that wraps into the bottom
        queue_char(1'b1, 8'd200, 9'd300, 8'd65, 16'hFFFF, 16'h0000);
        for (int k = 0; k < 5; k++)
            queue_char(1'b0, 8'd0, 9'd0, 8'd65, 16'hFFFF, 16'h0000);
        settle();

        // widest and tallest font: last glyph in the store, glyphs beyond it
        set_font(16, 32, 15);
        queue_char(1'b1, 8'd224, 9'd0, 8'd159, 16'hFFFF, 16'h0000);
        queue_char(1'b0, 8'd0, 9'd0, 8'd160, 16'hFFFF, 16'h0000);
        queue_char(1'b1, 8'd0, 9'd288, 8'd159, 16'h0000, 16'hFFFF);
        queue_char(1'b0, 8'd0, 9'd0, 8'd255, 16'h0000, 16'hFFFF);
        settle();

        // zero width and height act as one: first code, bottom right corner
        set_font(0, 0, 0);
        queue_char(1'b1, 8'd0, 9'd0, 8'd32, 16'h1111, 16'h2222);
        queue_char(1'b1, 8'd239, 9'd319, 8'd90, 16'h5555, 16'hAAAA);
        queue_char(1'b0, 8'd0, 9'd0, 8'd90, 16'h5555, 16'hAAAA);
        settle();

        // oversized width and height clamp to the limits
        set_font(31, 63, 0);
        queue_char(1'b1, 8'd100, 9'd100, 8'd160, 16'hAAAA, 16'h5555);
        queue_char(1'b0, 8'd0, 9'd0, 8'd159, 16'hAAAA, 16'h5555);

        random_phase(14, 85, 15, 1'b0);
        random_phase(85, 14, 15, 1'b1);
        random_phase(0, 0, 15, 1'b0);

        settle();
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
